// ===== design/sfp_pkg.sv =====
package sfp_pkg;

  localparam int unsigned DATA_W = 8;

  // start-of-frame markers
  localparam logic [DATA_W-1:0] START_SYNC  = 8'hC8;
  localparam logic [DATA_W-1:0] START_BCAST = 8'h00;
  localparam logic [DATA_W-1:0] START_EXT   = 8'hEE;

  localparam logic [DATA_W-1:0] CRC_POLY = 8'hD5;

  function automatic logic is_start(input logic [DATA_W-1:0] b);
    return (b == START_SYNC) || (b == START_BCAST) || (b == START_EXT);
  endfunction

  // one byte of CRC-8, MSB first, eight shift steps
  function automatic logic [DATA_W-1:0] crc8_update(input logic [DATA_W-1:0] crc,
                                                    input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[DATA_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/serial_frame_parser_crc8_top.sv =====
// Channel  Ports                           Payload
// -------  ------------------------------  ------------------------------------------
// input    in_tvalid/in_tready/in_tdata    data_byte
// output   out_tvalid/out_tready/out_tdata frame_byte, byte_index, frame_length,
//          out_tlast                       crc_good; last on tlast
//
// Receive: one byte accepted per cycle while in_tready is high; one buffer write per frame byte.
// Readout: after the final byte the buffer is read once per cycle unless out_tready
// stalls it; in_tready is low for the whole readout.
// The buffer read register is the output register and holds while out_tready is low.
// Reset (rst_n low, synchronous) returns to hunting for a start byte; no buffer clear.
module serial_frame_parser_crc8_top #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] frame_byte, [13:8] byte_index,
                                  // [20:14] frame_length, [21] crc_good, [23:22] zero
  output logic        out_tlast
);
  import sfp_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_FRAME);
  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  typedef enum logic [1:0] {
    ST_RX = 2'b01,
    ST_TX = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [DATA_W-1:0] crc_r, crc_nxt;
  logic              good_r, good_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              we;
  logic [AW-1:0]     waddr;
  logic              re;
  logic [DATA_W-1:0] rdata;
  logic [9:0]        len_sum;
  logic              slot_free;

  assign in_tready = (state_r == ST_RX);
  assign in_fire   = in_tvalid && in_tready;
  assign len_sum   = 10'(in_tdata) + 10'd2;
  assign waddr     = held_r[AW-1:0];
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    total_nxt     = total_r;
    crc_nxt       = crc_r;
    good_nxt      = good_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    re            = 1'b0;
    case (state_r)
      ST_RX: begin
        if (in_fire) begin
          if (held_r == '0) begin
            if (is_start(in_tdata)) begin
              we       = 1'b1;
              held_nxt = CNT_W'(1);
              crc_nxt  = '0;
            end
          end else if (held_r == CNT_W'(1)) begin
            if (in_tdata < 8'd2 || len_sum > 10'(MAX_FRAME)) begin
              held_nxt  = '0;
              total_nxt = '0;
              crc_nxt   = '0;
            end else begin
              we        = 1'b1;
              held_nxt  = CNT_W'(2);
              total_nxt = CNT_W'(len_sum);
              crc_nxt   = '0;
            end
          end else begin
            we       = 1'b1;
            held_nxt = held_r + CNT_W'(1);
            if (held_r + CNT_W'(1) < total_r) begin
              crc_nxt = crc8_update(crc_r, in_tdata);
            end else begin
              // final byte carries the check value; crc is not advanced over it
              good_nxt   = (crc_r == in_tdata);
              held_nxt   = '0;
              crc_nxt    = '0;
              rd_cnt_nxt = '0;
              state_nxt  = ST_TX;
            end
          end
        end
      end
      ST_TX: begin
        if (slot_free) begin
          if (rd_cnt_r != total_r) begin
            re            = 1'b1;
            out_valid_nxt = 1'b1;
            out_idx_nxt   = rd_cnt_r;
            out_last_nxt  = (rd_cnt_r + CNT_W'(1) == total_r);
            rd_cnt_nxt    = rd_cnt_r + CNT_W'(1);
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_RX;
          end
        end
      end
      default: begin
        state_nxt     = ST_RX;
        held_nxt      = '0;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      held_r      <= '0;
      total_r     <= '0;
      crc_r       <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      total_r     <= total_nxt;
      crc_r       <= crc_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    good_r     <= good_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  sfp_buf #(
    .DEPTH(MAX_FRAME)
  ) u_buf (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_tdata),
    .re   (re),
    .raddr(rd_cnt_r[AW-1:0]),
    .rdata(rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, good_r, 7'(32'(total_r)), 6'(32'(out_idx_r)), rdata};

endmodule

// ===== design/sfp_buf.sv =====
module sfp_buf #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [sfp_pkg::DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [sfp_pkg::DATA_W-1:0] rdata
);
  import sfp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low: it doubles as the output register
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sfp_chk.sv =====
module sfp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // input is closed for the whole readout
  a_no_rx_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input open during readout");

  // readout streams without gaps until the last byte
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside frame readout");

  // no result directly after the last byte of a frame
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result right after frame end");

  // last byte sits at index length-1
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> ((7'(out_tdata[13:8]) + 7'd1) == out_tdata[20:14]))
    else $error("last flag at wrong index");

endmodule

bind serial_frame_parser_crc8_top sfp_chk u_sfp_chk (.*);
